@@ hdl/tbh_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tbh_pkg
// Shared types, widths and constants of the track back-projection histogram.
// ----------------------------------------------------------------------------
package tbh_pkg;

    localparam int MAX_BINS_X_DEF = 128;
    localparam int MAX_BINS_Y_DEF = 128;

    // Width that holds any bin count up to the largest supported maximum.
    localparam int BIN_CW = 11;

    // Divider operand widths: magnitude of velocity times distance, and |vel_z|.
    localparam int DIV_DW = 56;
    localparam int DIV_VW = 24;

    localparam int IN_TDATA_W  = 168;
    localparam int OUT_TDATA_W = 96;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam int INT_W = 48;
    localparam int CNT_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_DIST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_SIZE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_X     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_Y     = 3'd5;

    // Configuration reset values.
    localparam logic signed [31:0] PROP_DIST_RST = 32'sd0;
    localparam logic signed [31:0] X_MIN_RST     = -32'sd500000;
    localparam logic signed [31:0] Y_MIN_RST     = -32'sd500000;
    localparam logic [19:0]        BIN_SIZE_RST  = 20'd10000;
    localparam logic [7:0]         BINS_X_RST    = 8'd100;
    localparam logic [7:0]         BINS_Y_RST    = 8'd100;

    // Item modes.
    localparam logic [1:0] MODE_ACCUM     = 2'd0;
    localparam logic [1:0] MODE_READ      = 2'd1;
    localparam logic [1:0] MODE_READ_CLR  = 2'd2;
    localparam logic [1:0] MODE_UNUSED    = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_QSTART,
        S_QWAIT,
        S_CHECK,
        S_BWAIT,
        S_RD,
        S_RMW,
        S_OUT
    } tbh_state_t;

    // Divider request and response.
    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_VW-1:0] divisor;
    } tbh_div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_DW-1:0] quotient;
        logic [DIV_VW-1:0] remainder;
    } tbh_div_rsp_t;

endpackage
`default_nettype wire

@@ hdl/track_backprojection_histogram_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// track_backprojection_histogram_top
// Straight-line track extrapolation into a weighted, saturating 2D histogram.
// ----------------------------------------------------------------------------
// A binned track takes four divisions on the shared divider, a quotient and a
// bin index on each axis; a window miss in x stops after the first division and
// one in y after the third; a read goes through the memory, or straight to the
// result when outside the store; zero vel_z and the unused mode go straight to
// the result. One word is in flight at a time. After reset the memories are
// cleared, one bin per cycle, over all MAX_BINS_X * MAX_BINS_Y bins; configuration
// writes are taken in every cycle outside reset.
// ----------------------------------------------------------------------------
module track_backprojection_histogram_top #(
    parameter int MAX_BINS_X = tbh_pkg::MAX_BINS_X_DEF,
    parameter int MAX_BINS_Y = tbh_pkg::MAX_BINS_Y_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Input words. tdata from bit 0: mode, track_x_um, track_y_um, vel_x,
    // vel_y, vel_z, track_weight, read_bin_x, read_bin_y.
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [tbh_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // Result words. tdata from bit 0: in_window, hit_bin_x, hit_bin_y,
    // bin_intensity, bin_count, one zero pad bit.
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [tbh_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // Configuration write channel.
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tbh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tbh_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tbh_pkg::*;

    localparam int DEPTH = MAX_BINS_X * MAX_BINS_Y;
    localparam int AW    = $clog2(DEPTH);
    localparam int BXW   = $clog2(MAX_BINS_X);
    localparam int BYW   = $clog2(MAX_BINS_Y);
    localparam logic [BIN_CW-1:0] MAXX_C = BIN_CW'(MAX_BINS_X);
    localparam logic [BIN_CW-1:0] MAXY_C = BIN_CW'(MAX_BINS_Y);
    localparam int RW    = 58;   // signed width of the relative position

    // ---------------------------------------------------------------- config
    logic signed [31:0] dz_reg, xmin_reg, ymin_reg;
    logic [19:0]        bsz_reg;
    logic [7:0]         nbx_reg, nby_reg;

    // Writes are refused only while reset is held.
    assign cfg_ready = rst_n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_reg   <= PROP_DIST_RST;
            xmin_reg <= X_MIN_RST;
            ymin_reg <= Y_MIN_RST;
            bsz_reg  <= BIN_SIZE_RST;
            nbx_reg  <= BINS_X_RST;
            nby_reg  <= BINS_Y_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PROP_DIST: dz_reg   <= cfg_data;
                CFG_X_MIN:     xmin_reg <= cfg_data;
                CFG_Y_MIN:     ymin_reg <= cfg_data;
                CFG_BIN_SIZE:  bsz_reg  <= cfg_data[19:0];
                CFG_BINS_X:    nbx_reg  <= cfg_data[7:0];
                CFG_BINS_Y:    nby_reg  <= cfg_data[7:0];
                default:       ;
            endcase
        end
    end

    // A zero bin size acts as one; bin counts are clamped to [1, maximum].
    logic [19:0]       bsz_eff;
    logic [BIN_CW-1:0] nx_eff, ny_eff;

    always_comb
    begin
        bsz_eff = (bsz_reg == 20'd0) ? 20'd1 : bsz_reg;
        if (nbx_reg == 8'd0)
            nx_eff = BIN_CW'(1);
        else if (BIN_CW'(nbx_reg) > MAXX_C)
            nx_eff = MAXX_C;
        else
            nx_eff = BIN_CW'(nbx_reg);
        if (nby_reg == 8'd0)
            ny_eff = BIN_CW'(1);
        else if (BIN_CW'(nby_reg) > MAXY_C)
            ny_eff = MAXY_C;
        else
            ny_eff = BIN_CW'(nby_reg);
    end

    // ---------------------------------------------------------- input fields
    logic [1:0]         in_mode;
    logic signed [23:0] in_x, in_y, in_vx, in_vy, in_vz;
    logic [31:0]        in_w;
    logic [6:0]         in_rbx, in_rby;

    assign in_mode = s_axis_tdata[1:0];
    assign in_x    = s_axis_tdata[25:2];
    assign in_y    = s_axis_tdata[49:26];
    assign in_vx   = s_axis_tdata[73:50];
    assign in_vy   = s_axis_tdata[97:74];
    assign in_vz   = s_axis_tdata[121:98];
    assign in_w    = s_axis_tdata[153:122];
    assign in_rbx  = s_axis_tdata[160:154];
    assign in_rby  = s_axis_tdata[167:161];

    // -------------------------------------------------------------- datapath
    tbh_state_t state_reg, state_next;

    logic [1:0]             mode_reg, mode_next;
    logic signed [23:0]     x0_reg, x0_next, y0_reg, y0_next, vz_reg, vz_next;
    logic [31:0]            w_reg, w_next;
    logic signed [55:0]     prx_reg, prx_next, pry_reg, pry_next;
    logic [30:0]            wdx_reg, wdx_next, wdy_reg, wdy_next;
    logic [BIN_CW-1:0]      nx_reg, nx_next, ny_reg, ny_next;
    logic [19:0]            bsz_e_reg, bsz_e_next;
    logic                   axis_reg, axis_next;
    logic signed [RW-1:0]   rel_reg, rel_next;
    logic                   frac_reg, frac_next;
    logic [BXW-1:0]         bx_reg, bx_next;
    logic [BYW-1:0]         by_reg, by_next;
    logic [AW-1:0]          clr_reg, clr_next;

    logic                   oinw_reg, oinw_next;
    logic [6:0]             obx_reg, obx_next, oby_reg, oby_next;
    logic [INT_W-1:0]       oint_reg, oint_next;
    logic [CNT_W-1:0]       ocnt_reg, ocnt_next;

    tbh_div_req_t div_req;
    tbh_div_rsp_t div_rsp;

    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_addr;
    logic [INT_W-1:0]       int_wdata, int_rdata;
    logic [CNT_W-1:0]       cnt_wdata, cnt_rdata;

    // Per-axis selection for the shared divider sequence.
    logic signed [55:0]     prod_sel;
    logic signed [23:0]     pos_sel;
    logic signed [31:0]     wmin_sel;
    logic [30:0]            width_sel;
    logic [BIN_CW-1:0]      n_sel;
    logic                   q_neg;
    logic [55:0]            prod_mag;
    logic [23:0]            vz_mag;
    logic signed [RW-1:0]   q_floor;
    logic                   rem_nz;
    logic [INT_W:0]         sum_wide;
    logic [BIN_CW-1:0]      bin_val;

    assign prod_sel  = axis_reg ? pry_reg : prx_reg;
    assign pos_sel   = axis_reg ? y0_reg : x0_reg;
    assign wmin_sel  = axis_reg ? ymin_reg : xmin_reg;
    assign width_sel = axis_reg ? wdy_reg : wdx_reg;
    assign n_sel     = axis_reg ? ny_reg : nx_reg;
    assign q_neg     = prod_sel[55] ^ vz_reg[23];
    assign prod_mag  = prod_sel[55] ? 56'(-prod_sel) : 56'(prod_sel);
    assign vz_mag    = vz_reg[23] ? 24'(-vz_reg) : 24'(vz_reg);
    assign rem_nz    = (div_rsp.remainder != '0);
    assign q_floor   = q_neg ? (-$signed({2'b00, div_rsp.quotient}) - RW'(rem_nz))
                             : $signed({2'b00, div_rsp.quotient});
    assign sum_wide  = {1'b0, int_rdata} + (INT_W + 1)'(w_reg);

    // Histogram address is row * MAX_BINS_X + column, or the clear pointer.
    assign ram_addr  = (state_reg == S_CLEAR) ? clr_reg
                     : AW'(AW'(by_reg) * AW'(MAX_BINS_X) + AW'(bx_reg));

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        x0_next    = x0_reg;
        y0_next    = y0_reg;
        vz_next    = vz_reg;
        w_next     = w_reg;
        prx_next   = prx_reg;
        pry_next   = pry_reg;
        wdx_next   = wdx_reg;
        wdy_next   = wdy_reg;
        nx_next    = nx_reg;
        ny_next    = ny_reg;
        bsz_e_next = bsz_e_reg;
        axis_next  = axis_reg;
        rel_next   = rel_reg;
        frac_next  = frac_reg;
        bx_next    = bx_reg;
        by_next    = by_reg;
        clr_next   = clr_reg;
        oinw_next  = oinw_reg;
        obx_next   = obx_reg;
        oby_next   = oby_reg;
        oint_next  = oint_reg;
        ocnt_next  = ocnt_reg;
        bin_val    = '0;

        div_req.start    = 1'b0;
        div_req.dividend = prod_mag;
        div_req.divisor  = vz_mag;

        ram_we    = 1'b0;
        ram_re    = 1'b0;
        int_wdata = '0;
        cnt_wdata = '0;

        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we   = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                    state_next = S_IDLE;
            end

            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    mode_next  = in_mode;
                    x0_next    = in_x;
                    y0_next    = in_y;
                    vz_next    = in_vz;
                    w_next     = in_w;
                    prx_next   = 56'(in_vx) * 56'(dz_reg);
                    pry_next   = 56'(in_vy) * 56'(dz_reg);
                    wdx_next   = 31'(nx_eff) * 31'(bsz_eff);
                    wdy_next   = 31'(ny_eff) * 31'(bsz_eff);
                    nx_next    = nx_eff;
                    ny_next    = ny_eff;
                    bsz_e_next = bsz_eff;
                    axis_next  = 1'b0;
                    oinw_next  = 1'b0;
                    obx_next   = '0;
                    oby_next   = '0;
                    oint_next  = '0;
                    ocnt_next  = '0;
                    case (in_mode)
                        MODE_ACCUM:
                        begin
                            if (in_vz != 24'sd0)
                                state_next = S_QSTART;
                            else
                                state_next = S_OUT;
                        end
                        MODE_READ, MODE_READ_CLR:
                        begin
                            obx_next = in_rbx;
                            oby_next = in_rby;
                            bx_next  = BXW'(in_rbx);
                            by_next  = BYW'(in_rby);
                            // Reads outside the store give zero sums.
                            if (BIN_CW'(in_rbx) < MAXX_C && BIN_CW'(in_rby) < MAXY_C)
                                state_next = S_RD;
                            else
                                state_next = S_OUT;
                        end
                        default:
                            state_next = S_OUT;
                    endcase
                end
            end

            S_QSTART:
            begin
                div_req.start = 1'b1;
                state_next    = S_QWAIT;
            end

            S_QWAIT:
            begin
                if (div_rsp.done)
                begin
                    rel_next   = RW'(pos_sel) + q_floor - RW'(wmin_sel);
                    frac_next  = rem_nz;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                div_req.dividend = rel_reg[55:0];
                div_req.divisor  = DIV_VW'(bsz_e_reg);
                // Inside when min <= x <= max on the exact rational position.
                if (rel_reg[RW-1] || (rel_reg > $signed(RW'(width_sel)))
                    || ((rel_reg == $signed(RW'(width_sel))) && frac_reg))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = S_BWAIT;
                end
            end

            S_BWAIT:
            begin
                if (div_rsp.done)
                begin
                    // A point on the upper edge lands in the last bin.
                    if (div_rsp.quotient >= DIV_DW'(n_sel))
                        bin_val = n_sel - BIN_CW'(1);
                    else
                        bin_val = div_rsp.quotient[BIN_CW-1:0];
                    if (axis_reg)
                    begin
                        by_next    = BYW'(bin_val);
                        state_next = S_RD;
                    end
                    else
                    begin
                        bx_next    = BXW'(bin_val);
                        axis_next  = 1'b1;
                        state_next = S_QSTART;
                    end
                end
            end

            S_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_RMW;
            end

            S_RMW:
            begin
                state_next = S_OUT;
                case (mode_reg)
                    MODE_ACCUM:
                    begin
                        ram_we    = 1'b1;
                        int_wdata = sum_wide[INT_W] ? '1 : sum_wide[INT_W-1:0];
                        cnt_wdata = (cnt_rdata == '1) ? cnt_rdata
                                                      : cnt_rdata + CNT_W'(1);
                        oinw_next = 1'b1;
                        obx_next  = 7'(bx_reg);
                        oby_next  = 7'(by_reg);
                        oint_next = int_wdata;
                        ocnt_next = cnt_wdata;
                    end
                    MODE_READ_CLR:
                    begin
                        ram_we    = 1'b1;
                        oint_next = int_rdata;
                        ocnt_next = cnt_rdata;
                    end
                    default:
                    begin
                        oint_next = int_rdata;
                        ocnt_next = cnt_rdata;
                    end
                endcase
            end

            S_OUT:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready)
                    state_next = S_IDLE;
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            axis_reg  <= axis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        x0_reg    <= x0_next;
        y0_reg    <= y0_next;
        vz_reg    <= vz_next;
        w_reg     <= w_next;
        prx_reg   <= prx_next;
        pry_reg   <= pry_next;
        wdx_reg   <= wdx_next;
        wdy_reg   <= wdy_next;
        nx_reg    <= nx_next;
        ny_reg    <= ny_next;
        bsz_e_reg <= bsz_e_next;
        rel_reg   <= rel_next;
        frac_reg  <= frac_next;
        bx_reg    <= bx_next;
        by_reg    <= by_next;
        oinw_reg  <= oinw_next;
        obx_reg   <= obx_next;
        oby_reg   <= oby_next;
        oint_reg  <= oint_next;
        ocnt_reg  <= ocnt_next;
    end

    assign m_axis_tdata = {1'b0, ocnt_reg, oint_reg, oby_reg, obx_reg, oinw_reg};

    // ------------------------------------------------------------- instances
    tbh_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    tbh_ram #(
        .WIDTH (INT_W),
        .DEPTH (DEPTH)
    ) u_int_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (int_wdata),
        .rdata (int_rdata)
    );

    tbh_ram #(
        .WIDTH (CNT_W),
        .DEPTH (DEPTH)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (cnt_wdata),
        .rdata (cnt_rdata)
    );

    // ------------------------------------------------------------ assertions
    // No input word is taken while a result is still on offer.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input taken while a result is pending");

    // The memory clear pass blocks input.
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !s_axis_tready)
        else $error("input accepted during clear pass");

    // A binned track always leaves a nonzero count in its bin.
    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[94:63] != '0))
        else $error("binned track reports zero count");

    // A divider start is never followed directly by another start.
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> !div_req.start)
        else $error("divider started on consecutive cycles");

endmodule
`default_nettype wire

@@ hdl/tbh_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tbh_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module tbh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule
`default_nettype wire

@@ hdl/tbh_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tbh_div
// Iterative restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tbh_div (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire tbh_pkg::tbh_div_req_t req,
    output tbh_pkg::tbh_div_rsp_t      rsp
);
    import tbh_pkg::*;

    localparam int CW = $clog2(DIV_DW + 1);

    logic [DIV_DW-1:0] dq_reg, dq_next;
    logic [DIV_VW:0]   rem_reg, rem_next;
    logic [DIV_VW-1:0] dsr_reg, dsr_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_VW:0]   trial;

    always_comb
    begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DIV_VW-1:0], dq_reg[DIV_DW-1]};
        if (req.start)
        begin
            dq_next   = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = CW'(DIV_DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = trial - {1'b0, dsr_reg};
                dq_next  = {dq_reg[DIV_DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                dq_next  = {dq_reg[DIV_DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dq_reg   <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            dq_reg   <= dq_next;
            rem_reg  <= rem_next;
            dsr_reg  <= dsr_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = dq_reg;
    assign rsp.remainder = rem_reg[DIV_VW-1:0];

endmodule
`default_nettype wire

@@ bench/track_backprojection_histogram_checker.sv @@
// ----------------------------------------------------------------------------
// track_backprojection_histogram_checker
// Watches the three channels, predicts every result word and compares it.
// ----------------------------------------------------------------------------
module track_backprojection_histogram_checker
    import tbh_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [IN_TDATA_W-1:0]  s_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [OUT_TDATA_W-1:0] m_data,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     errors,
    output int                     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBINS = MAX_BINS_X_DEF * MAX_BINS_Y_DEF;

    // Listed from the top bit down, so in_window lands in bit 0.
    typedef struct packed {
        logic [CNT_W-1:0]   count;
        logic [INT_W-1:0]   intensity;
        logic [6:0]         bin_y;
        logic [6:0]         bin_x;
        logic               in_window;
    } bin_result_t;

    logic [INT_W-1:0] weight_sum [NBINS];
    logic [CNT_W-1:0] track_hits [NBINS];

    longint dist_um, x_min_um, y_min_um;
    longint bin_um, cols_used, rows_used;

    bin_result_t pending_results[$];

    assign outstanding = pending_results.size();

    // Exact floor of vel * dz / vz, then the window and bin test on one axis.
    function automatic logic axis_locate(longint p0, longint vel, longint vz, longint wmin,
                                         longint nb, longint bsz, output longint bin);
        longint num, den, q, r, rel, span;
        num = vel * dist_um;
        den = vz;
        bin = 0;
        if (den < 0)
        begin
            num = -num;
            den = -den;
        end
        q = num / den;
        r = num % den;
        if (r < 0)
        begin
            q = q - 1;
            r = r + den;
        end
        rel  = p0 + q - wmin;
        span = nb * bsz;
        if (rel < 0 || rel > span || (rel == span && r != 0))
            return 1'b0;
        bin = rel / bsz;
        if (bin >= nb)
            bin = nb - 1;
        return 1'b1;
    endfunction

    function automatic bin_result_t predict_bin(logic [IN_TDATA_W-1:0] d);
        bin_result_t res;
        logic [1:0] mode;
        longint bsz, nx, ny, cx, cy, vz;
        logic [63:0] total;
        int idx;
        res  = '0;
        mode = d[1:0];
        if (mode == MODE_ACCUM)
        begin
            bsz = (bin_um == 0) ? 1 : bin_um;
            nx  = (cols_used < 1) ? 1 : (cols_used > MAX_BINS_X_DEF) ? MAX_BINS_X_DEF : cols_used;
            ny  = (rows_used < 1) ? 1 : (rows_used > MAX_BINS_Y_DEF) ? MAX_BINS_Y_DEF : rows_used;
            vz  = longint'($signed(d[121:98]));
            if (vz != 0
                && axis_locate(longint'($signed(d[25:2])), longint'($signed(d[73:50])), vz,
                               x_min_um, nx, bsz, cx)
                && axis_locate(longint'($signed(d[49:26])), longint'($signed(d[97:74])), vz,
                               y_min_um, ny, bsz, cy))
            begin
                idx   = int'(cy) * MAX_BINS_X_DEF + int'(cx);
                total = 64'(weight_sum[idx]) + 64'(d[153:122]);
                if (total > 64'hFFFF_FFFF_FFFF)
                    total = 64'hFFFF_FFFF_FFFF;
                weight_sum[idx] = total[47:0];
                if (track_hits[idx] != '1)
                    track_hits[idx] = track_hits[idx] + 1;
                res.in_window = 1'b1;
                res.bin_x     = cx[6:0];
                res.bin_y     = cy[6:0];
                res.intensity = weight_sum[idx];
                res.count     = track_hits[idx];
            end
        end
        else if (mode == MODE_READ || mode == MODE_READ_CLR)
        begin
            res.bin_x     = d[160:154];
            res.bin_y     = d[167:161];
            idx           = int'(res.bin_y) * MAX_BINS_X_DEF + int'(res.bin_x);
            res.intensity = weight_sum[idx];
            res.count     = track_hits[idx];
            if (mode == MODE_READ_CLR)
            begin
                weight_sum[idx] = '0;
                track_hits[idx] = '0;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NBINS; i++)
            begin
                weight_sum[i] = '0;
                track_hits[i] = '0;
            end
            dist_um   = longint'(PROP_DIST_RST);
            x_min_um  = longint'(X_MIN_RST);
            y_min_um  = longint'(Y_MIN_RST);
            bin_um    = longint'(BIN_SIZE_RST);
            cols_used = longint'(BINS_X_RST);
            rows_used = longint'(BINS_Y_RST);
            errors    = 0;
            pending_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PROP_DIST: dist_um   = longint'($signed(cfg_data));
                    CFG_X_MIN:     x_min_um  = longint'($signed(cfg_data));
                    CFG_Y_MIN:     y_min_um  = longint'($signed(cfg_data));
                    CFG_BIN_SIZE:  bin_um    = longint'(cfg_data[19:0]);
                    CFG_BINS_X:    cols_used = longint'(cfg_data[7:0]);
                    CFG_BINS_Y:    rows_used = longint'(cfg_data[7:0]);
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                pending_results.push_back(predict_bin(s_data));
            if (m_valid && m_ready)
            begin
                bin_result_t got, want;
                got = bin_result_t'(m_data[94:0]);
                if (pending_results.size() == 0)
                begin
                    $error("result word with nothing expected: %h", m_data);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.in_window !== want.in_window)
                    begin
                        $error("in_window expected %0d got %0d", want.in_window, got.in_window);
                        errors++;
                    end
                    if (got.bin_x !== want.bin_x)
                    begin
                        $error("hit_bin_x expected %0d got %0d", want.bin_x, got.bin_x);
                        errors++;
                    end
                    if (got.bin_y !== want.bin_y)
                    begin
                        $error("hit_bin_y expected %0d got %0d", want.bin_y, got.bin_y);
                        errors++;
                    end
                    if (got.intensity !== want.intensity)
                    begin
                        $error("bin_intensity expected %0d got %0d", want.intensity,
                               got.intensity);
                        errors++;
                    end
                    if (got.count !== want.count)
                    begin
                        $error("bin_count expected %0d got %0d", want.count, got.count);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

@@ bench/track_backprojection_histogram_top_test.sv @@
// ----------------------------------------------------------------------------
// track_backprojection_histogram_top_test
// Drives tracks and bin reads into the histogram under several window
// settings and idling patterns; the checker beside the block judges results.
// ----------------------------------------------------------------------------
module track_backprojection_histogram_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import tbh_pkg::*;

    localparam longint CYCLE_LIMIT = 3_000_000;
    localparam int     WORDS_PER_PHASE = 320;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int     errors;
    int     outstanding;
    longint cycles;
    int     send_idle_pct;
    int     recv_idle_pct;
    logic   hold_off;
    int     phase;

    // Window settings for each phase: dz, x min, y min, bin size, columns, rows.
    // The later phases reach the register extremes and the clamped values.
    longint ph_dist  [4] = '{2000, -64'sd2147483648, 2147483647, -1000};
    longint ph_xmin  [4] = '{-500000, -64'sd2147483648, 100000, -3000};
    longint ph_ymin  [4] = '{-500000, -64'sd2147483648, -1, -3000};
    longint ph_bin   [4] = '{10000, 1048575, 0, 50};
    longint ph_cols  [4] = '{100, 0, 128, 255};
    longint ph_rows  [4] = '{100, 255, 1, 128};

    track_backprojection_histogram_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    track_backprojection_histogram_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_valid     (s_axis_tvalid),
        .s_ready     (s_axis_tready),
        .s_data      (s_axis_tdata),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_data      (m_axis_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The run is cut short if the block stops making progress.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // The receiver idles at the current rate, or refuses every result during a hold-off.
    always @(posedge clk)
    begin
        if (hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // In the last phase the receiver refuses results for a long stretch while
    // words keep being offered, so the block fills and stops taking input.
    initial
    begin
        hold_off = 1'b0;
        wait (phase == 3);
        repeat (200) @(posedge clk);
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
    end

    function automatic logic [IN_TDATA_W-1:0] pack_word(
        logic [1:0] mode, longint x0, longint y0, longint vx, longint vy, longint vz,
        logic [31:0] weight, logic [6:0] rbx, logic [6:0] rby);
        return {rby, rbx, weight, vz[23:0], vy[23:0], vx[23:0], y0[23:0], x0[23:0], mode};
    endfunction

    // Offers one word, holding valid high between back-to-back words so it is
    // never lowered and raised again without a clock edge in between.
    task automatic send_word(logic [IN_TDATA_W-1:0] word);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Drops the sender's valid, then waits until every expected result word has
    // come back and the block is quiet.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_window(int p);
        longint vals[6];
        logic [CFG_IDX_W-1:0] idx[6];
        vals = '{ph_dist[p], ph_xmin[p], ph_ymin[p], ph_bin[p], ph_cols[p], ph_rows[p]};
        idx  = '{CFG_PROP_DIST, CFG_X_MIN, CFG_Y_MIN, CFG_BIN_SIZE, CFG_BINS_X, CFG_BINS_Y};
        for (int i = 0; i < 6; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i][31:0];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic longint rand_signed24();
        return longint'($signed(24'($urandom())));
    endfunction

    // Picks a velocity that carries x0 close to the wanted landing point, so
    // that most tracks fall in or near the window whatever dz is.
    function automatic longint aim_velocity(longint target, longint x0, longint vz,
                                            longint dz);
        longint v;
        if (dz == 0)
            return rand_signed24();
        v = ((target - x0) * vz) / dz;
        if (v > 8388607)
            v = 8388607;
        if (v < -8388608)
            v = -8388608;
        return v;
    endfunction

    function automatic longint pick_target(longint wmin, longint bsz, longint nb);
        longint b, n;
        b = (bsz == 0) ? 1 : bsz;
        n = (nb < 1) ? 1 : (nb > 128) ? 128 : nb;
        case ($urandom_range(9))
            0: return wmin;
            1: return wmin + n * b;
            2: return wmin + n * b + 1;
            3: return wmin - 1;
            default: return wmin - b + longint'($urandom_range(32'(n * b + 2 * b)));
        endcase
    endfunction

    function automatic logic [IN_TDATA_W-1:0] random_word(int p);
        int     kind;
        longint x0, y0, vx, vy, vz, tx, ty;
        logic [31:0] weight;
        kind   = $urandom_range(99);
        weight = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : 32'($urandom());
        if (kind < 70)
        begin
            tx = pick_target(ph_xmin[p], ph_bin[p], ph_cols[p]);
            ty = pick_target(ph_ymin[p], ph_bin[p], ph_rows[p]);
            if (ph_dist[p] == 0)
            begin
                x0 = tx;
                y0 = ty;
            end
            else
            begin
                x0 = rand_signed24();
                y0 = rand_signed24();
            end
            do
                vz = rand_signed24() >>> $urandom_range(20);
            while (vz == 0);
            vx = aim_velocity(tx, x0, vz, ph_dist[p]);
            vy = aim_velocity(ty, y0, vz, ph_dist[p]);
            if ($urandom_range(49) == 0)
                vz = 0;
            return pack_word(MODE_ACCUM, x0, y0, vx, vy, vz, weight, 7'($urandom()),
                             7'($urandom()));
        end
        else if (kind < 85)
            return pack_word($urandom_range(1) ? MODE_READ : MODE_READ_CLR, rand_signed24(),
                             rand_signed24(), rand_signed24(), rand_signed24(),
                             rand_signed24(), 32'($urandom()), 7'($urandom()),
                             7'($urandom()));
        else if (kind < 90)
            return pack_word(MODE_UNUSED, 0, 0, 0, 0, 0, 32'($urandom()), 7'($urandom()),
                             7'($urandom()));
        else
            return IN_TDATA_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                                $urandom()});
    endfunction

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        m_axis_tready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        phase         = -1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words under the reset window: dz is 0, so tracks land where
        // they start. Window spans -500000 to 500000 in both axes.
        send_word(pack_word(MODE_ACCUM, -500000, -500000, 1, 1, 1, 32'h0001_0000, 0, 0));
        send_word(pack_word(MODE_ACCUM, 500000, 500000, 1, 1, 1, 32'hFFFF_FFFF, 0, 0));
        send_word(pack_word(MODE_ACCUM, 500000, 500000, -1, -1, -8388608, 32'hFFFF_FFFF,
                            0, 0));
        send_word(pack_word(MODE_ACCUM, 500001, 0, 1, 1, 1, 32'd5, 0, 0));
        send_word(pack_word(MODE_ACCUM, -500001, 0, 1, 1, 1, 32'd5, 0, 0));
        send_word(pack_word(MODE_ACCUM, 0, 0, 8388607, -8388608, 0, 32'd7, 0, 0));
        send_word(pack_word(MODE_ACCUM, 8388607, -8388608, 8388607, 8388607, 8388607,
                            32'd1, 0, 0));
        send_word(pack_word(MODE_ACCUM, 4999, 4999, 0, 0, -1, 32'd0, 0, 0));
        send_word(pack_word(MODE_READ, 0, 0, 0, 0, 0, 0, 99, 99));
        send_word(pack_word(MODE_READ_CLR, 0, 0, 0, 0, 0, 0, 99, 99));
        send_word(pack_word(MODE_READ, 0, 0, 0, 0, 0, 0, 99, 99));
        send_word(pack_word(MODE_READ, 0, 0, 0, 0, 0, 0, 127, 127));
        send_word(pack_word(MODE_READ_CLR, -1, -1, -1, -1, -1, 32'hFFFF_FFFF, 0, 0));
        send_word(pack_word(MODE_UNUSED, 1, 1, 1, 1, 1, 32'd9, 5, 5));
        drain_results();

        // With dz of 1000 a track lands a third of a micrometre past the upper
        // edge, which is a miss; exactly on the edge it goes into the last bin;
        // a negative fraction rounds down.
        cfg_valid <= 1'b1;
        cfg_index <= CFG_PROP_DIST;
        cfg_data  <= 32'd1000;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        send_word(pack_word(MODE_ACCUM, 500000 - 333, 0, 1, 0, 3, 32'd1, 0, 0));
        send_word(pack_word(MODE_ACCUM, 500000 - 334, 0, 1, 0, 3, 32'd1, 0, 0));
        send_word(pack_word(MODE_ACCUM, 499999, 499999, 1, 1, 1000, 32'd2, 0, 0));
        send_word(pack_word(MODE_ACCUM, -499667, 0, -1, 0, 3, 32'd3, 0, 0));
        send_word(pack_word(MODE_ACCUM, -499666, 0, -1, 0, 3, 32'd3, 0, 0));
        drain_results();

        for (int p = 0; p < 4; p++)
        begin
            write_window(p);
            case (p)
                0:
                begin
                    send_idle_pct = 34;
                    recv_idle_pct = 61;
                end
                1:
                begin
                    send_idle_pct = 61;
                    recv_idle_pct = 34;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase = p;
            for (int n = 0; n < WORDS_PER_PHASE; n++)
                send_word(random_word(p));
            drain_results();
        end

        repeat (300) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
